// ----- hdl/ltfe_pkg.sv -----
// ---------------------------------------------------------------------------
// ltfe_pkg
// types and constants shared by the tlv field extractor modules
// ---------------------------------------------------------------------------
package ltfe_pkg;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       frame_last;
   } ltfe_req_type;

   typedef struct packed {
      logic [6:0]  tlv_type;
      logic [8:0]  tlv_length;
      logic [1:0]  value_kind;
      logic [47:0] field_value;
      logic        truncated;
      logic        frame_done;
   } ltfe_rsp_type;

   typedef enum logic [1:0] {
      PH_HDR0  = 2'd0,
      PH_HDR1  = 2'd1,
      PH_VALUE = 2'd2,
      PH_DONE  = 2'd3
   } ltfe_phase_type;

   localparam logic [6:0]  TLV_END     = 7'd0;
   localparam logic [6:0]  TLV_CHASSIS = 7'd1;
   localparam logic [6:0]  TLV_PORT    = 7'd2;
   localparam logic [6:0]  TLV_ORG     = 7'd127;

   localparam logic [7:0]  SUB_CHASSIS_MAC = 8'h04;
   localparam logic [7:0]  SUB_PORT_MAC    = 8'h03;
   localparam logic [31:0] ORG_PORT_VLAN   = 32'h0080_C201;

   localparam logic [8:0]  MAC_MIN_LEN  = 9'd7;
   localparam logic [8:0]  VLAN_MIN_LEN = 9'd6;

   localparam logic [1:0]  KIND_NONE        = 2'd0;
   localparam logic [1:0]  KIND_CHASSIS_MAC = 2'd1;
   localparam logic [1:0]  KIND_PORT_MAC    = 2'd2;
   localparam logic [1:0]  KIND_PORT_VLAN   = 2'd3;

endpackage

// ----- hdl/ltfe_parser.sv -----
// ---------------------------------------------------------------------------
// ltfe_parser
// tlv walk state and per-byte result decode
// ---------------------------------------------------------------------------
module ltfe_parser
   import ltfe_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         step,
   input  ltfe_req_type word,
   output logic         res_valid,
   output ltfe_rsp_type res_word
);

   ltfe_phase_type phase_ff, phase_in;
   logic [6:0]     type_ff, type_in;
   logic [8:0]     len_ff, len_in;
   logic [8:0]     idx_ff, idx_in;
   logic [31:0]    pre_ff, pre_in;
   logic [47:0]    shf_ff, shf_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_HDR0;
         type_ff  <= '0;
         len_ff   <= '0;
         idx_ff   <= '0;
         pre_ff   <= '0;
         shf_ff   <= '0;
      end else if (step) begin
         if (word.frame_last) begin
            phase_ff <= PH_HDR0;
            type_ff  <= '0;
            len_ff   <= '0;
            idx_ff   <= '0;
            pre_ff   <= '0;
            shf_ff   <= '0;
         end else begin
            phase_ff <= phase_in;
            type_ff  <= type_in;
            len_ff   <= len_in;
            idx_ff   <= idx_in;
            pre_ff   <= pre_in;
            shf_ff   <= shf_in;
         end
      end
   end

   logic [7:0] b;
   logic       last;
   logic       complete;
   logic       trunc_only;
   logic [7:0] subtype;

   always_comb begin
      b          = word.data_byte;
      last       = word.frame_last;
      phase_in   = phase_ff;
      type_in    = type_ff;
      len_in     = len_ff;
      idx_in     = idx_ff;
      pre_in     = pre_ff;
      shf_in     = shf_ff;
      complete   = 1'b0;
      trunc_only = 1'b0;
      res_valid  = 1'b0;
      res_word   = '0;

      case (phase_ff)
         PH_HDR0: begin
            type_in    = b[7:1];
            len_in     = {b[0], 8'h00};
            phase_in   = PH_HDR1;
            trunc_only = last;
         end
         PH_HDR1: begin
            len_in = {len_ff[8], b};
            idx_in = '0;
            pre_in = '0;
            shf_in = '0;
            if (type_ff == TLV_END) begin
               res_valid           = 1'b1;
               res_word.frame_done = 1'b1;
               phase_in            = PH_DONE;
            end else if (len_in == 9'd0) begin
               complete = 1'b1;
               phase_in = PH_HDR0;
            end else begin
               phase_in   = PH_VALUE;
               trunc_only = last;
            end
         end
         PH_VALUE: begin
            if (idx_ff < 9'd4)
               pre_in = {pre_ff[23:0], b};
            if (type_ff == TLV_ORG) begin
               if (idx_ff == 9'd4 || idx_ff == 9'd5)
                  shf_in = {shf_ff[39:0], b};
            end else if (idx_ff >= 9'd1 && idx_ff <= 9'd6) begin
               shf_in = {shf_ff[39:0], b};
            end
            idx_in = idx_ff + 9'd1;
            if (idx_in >= len_ff) begin
               complete = 1'b1;
               phase_in = PH_HDR0;
            end else begin
               trunc_only = last;
            end
         end
         default: begin
         end
      endcase

      subtype = pre_in[31:24];
      if (complete) begin
         res_valid           = 1'b1;
         res_word.truncated  = last;
         res_word.frame_done = last;
         if (type_in == TLV_CHASSIS && len_in >= MAC_MIN_LEN
             && subtype == SUB_CHASSIS_MAC) begin
            res_word.value_kind  = KIND_CHASSIS_MAC;
            res_word.field_value = shf_in;
         end else if (type_in == TLV_PORT && len_in >= MAC_MIN_LEN
                      && subtype == SUB_PORT_MAC) begin
            res_word.value_kind  = KIND_PORT_MAC;
            res_word.field_value = shf_in;
         end else if (type_in == TLV_ORG && len_in >= VLAN_MIN_LEN
                      && pre_in == ORG_PORT_VLAN) begin
            res_word.value_kind  = KIND_PORT_VLAN;
            res_word.field_value = {32'h0, shf_in[15:0]};
         end else begin
            res_word.value_kind  = KIND_NONE;
         end
      end else if (trunc_only) begin
         res_valid           = 1'b1;
         res_word.truncated  = 1'b1;
         res_word.frame_done = 1'b1;
      end
      res_word.tlv_type   = type_in;
      res_word.tlv_length = len_in;
   end

endmodule

// ----- hdl/ltfe_out_skid.sv -----
// ---------------------------------------------------------------------------
// ltfe_out_skid
// result register with one skid word; full comes from a register, not rsp_stall
// ---------------------------------------------------------------------------
module ltfe_out_skid
   import ltfe_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   input  ltfe_rsp_type push_word,
   output logic         full,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output ltfe_rsp_type rsp_word
);

   logic         out_valid_ff;
   logic         hold_valid_ff;
   ltfe_rsp_type out_ff;
   ltfe_rsp_type hold_ff;
   logic         take;

   assign take      = out_valid_ff && !rsp_stall;
   assign full      = hold_valid_ff;
   assign rsp_valid = out_valid_ff;
   assign rsp_word  = out_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         hold_valid_ff <= 1'b0;
      end else if (hold_valid_ff) begin
         if (take)
            hold_valid_ff <= 1'b0;
      end else if (push) begin
         if (!out_valid_ff || take)
            out_valid_ff <= 1'b1;
         else
            hold_valid_ff <= 1'b1;
      end else if (take) begin
         out_valid_ff <= 1'b0;
      end
   end

   // payload moves without reset
   always_ff @(posedge clock) begin
      if (hold_valid_ff) begin
         if (take)
            out_ff <= hold_ff;
      end else if (push) begin
         if (!out_valid_ff || take)
            out_ff <= push_word;
         else
            hold_ff <= push_word;
      end
   end

endmodule

// ----- hdl/lldp_tlv_field_extractor_core.sv -----
// ---------------------------------------------------------------------------
// lldp_tlv_field_extractor_core
// output: a result word goes into the result register, or into the skid word while rsp is stalled
// throughput: one payload byte per cycle while the skid word is free, set by the single parse state update
// reset: synchronous, parser back to first header byte, no result pending
// ---------------------------------------------------------------------------
module lldp_tlv_field_extractor_core
   import ltfe_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   // payload byte channel
   input  logic         req_valid,
   output logic         req_stall,
   input  ltfe_req_type req_word,
   // completed tlv channel
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output ltfe_rsp_type rsp_word
);

   // a byte is taken whenever the skid word is free
   logic         skid_full;
   logic         step;
   logic         res_valid;
   ltfe_rsp_type res_word;

   assign req_stall = skid_full;
   assign step      = req_valid && !skid_full;

   // tlv walk: header bytes, value bytes, and after the end tlv ignore until frame end
   ltfe_parser u_parser (
      .clock     (clock),
      .reset     (reset),
      .step      (step),
      .word      (req_word),
      .res_valid (res_valid),
      .res_word  (res_word)
   );

   // result register plus skid word; at most one result per byte
   ltfe_out_skid u_out (
      .clock     (clock),
      .reset     (reset),
      .push      (step && res_valid),
      .push_word (res_word),
      .full      (skid_full),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word)
   );

endmodule

// ----- verif/tb_top.sv -----
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_top
// testbench for lldp_tlv_field_extractor_core: drives lldp payload frames
// byte by byte under random idling and back-pressure, predicts every
// completed tlv word and compares it field by field with the rsp channel
// ---------------------------------------------------------------------------
module tb_top;

   import ltfe_pkg::*;

   localparam int CLK_HALF    = 4;
   localparam int RESET_CYCLES = 7;
   localparam int IDLE_PCT    = 19;
   localparam int RANDOM_BYTES = 1700;
   localparam int CYCLE_LIMIT = 200000;

   // -------------------------------------------------------------------------
   // tlv parse predictor and store of expected result words
   // -------------------------------------------------------------------------
   class tlv_scoreboard;
      ltfe_phase_type phase;
      logic [6:0]     cur_type;
      logic [8:0]     cur_len;
      logic [8:0]     val_idx;
      logic [31:0]    lead_bytes;
      logic [47:0]    val_bytes;
      ltfe_rsp_type   expected_q[$];
      int             errors;
      int             n_checked;
      int             n_field;
      int             n_trunc;

      function new();
         errors    = 0;
         n_checked = 0;
         n_field   = 0;
         n_trunc   = 0;
         clear_parser();
      endfunction

      function void clear_parser();
         phase      = PH_HDR0;
         cur_type   = '0;
         cur_len    = '0;
         val_idx    = '0;
         lead_bytes = '0;
         val_bytes  = '0;
      endfunction

      function void push_word(logic [1:0] kind, logic [47:0] value, logic trunc, logic done);
         ltfe_rsp_type w;
         w.tlv_type    = cur_type;
         w.tlv_length  = cur_len;
         w.value_kind  = kind;
         w.field_value = value;
         w.truncated   = trunc;
         w.frame_done  = done;
         expected_q.push_back(w);
      endfunction

      // a tlv whose value is complete: pick out the mac or vlan if it carries one
      function void push_complete(logic last);
         if (cur_type == TLV_CHASSIS && cur_len >= MAC_MIN_LEN
               && lead_bytes[31:24] == SUB_CHASSIS_MAC) begin
            push_word(KIND_CHASSIS_MAC, val_bytes, last, last);
         end else if (cur_type == TLV_PORT && cur_len >= MAC_MIN_LEN
               && lead_bytes[31:24] == SUB_PORT_MAC) begin
            push_word(KIND_PORT_MAC, val_bytes, last, last);
         end else if (cur_type == TLV_ORG && cur_len >= VLAN_MIN_LEN
               && lead_bytes == ORG_PORT_VLAN) begin
            push_word(KIND_PORT_VLAN, {32'h0, val_bytes[15:0]}, last, last);
         end else begin
            push_word(KIND_NONE, '0, last, last);
         end
      endfunction

      function void note_byte(ltfe_req_type w);
         logic [7:0] b;
         logic       last;
         b    = w.data_byte;
         last = w.frame_last;
         case (phase)
            PH_HDR0: begin
               cur_type = b[7:1];
               cur_len  = {b[0], 8'h00};
               phase    = PH_HDR1;
               if (last) push_word(KIND_NONE, '0, 1'b1, 1'b1);
            end
            PH_HDR1: begin
               cur_len    = cur_len | {1'b0, b};
               val_idx    = '0;
               lead_bytes = '0;
               val_bytes  = '0;
               if (cur_type == TLV_END) begin
                  push_word(KIND_NONE, '0, 1'b0, 1'b1);
                  phase = PH_DONE;
               end else if (cur_len == 9'd0) begin
                  push_complete(last);
                  phase = PH_HDR0;
               end else begin
                  phase = PH_VALUE;
                  if (last) push_word(KIND_NONE, '0, 1'b1, 1'b1);
               end
            end
            PH_VALUE: begin
               if (val_idx < 9'd4) lead_bytes = {lead_bytes[23:0], b};
               if (cur_type == TLV_ORG) begin
                  if (val_idx == 9'd4 || val_idx == 9'd5) val_bytes = {val_bytes[39:0], b};
               end else if (val_idx >= 9'd1 && val_idx <= 9'd6) begin
                  val_bytes = {val_bytes[39:0], b};
               end
               val_idx = val_idx + 9'd1;
               if (val_idx >= cur_len) begin
                  push_complete(last);
                  phase = PH_HDR0;
               end else if (last) begin
                  push_word(KIND_NONE, '0, 1'b1, 1'b1);
               end
            end
            default: ;
         endcase
         if (last) clear_parser();
      endfunction

      function int pending();
         return expected_q.size();
      endfunction

      function void check_word(ltfe_rsp_type got);
         ltfe_rsp_type exp_w;
         if (expected_q.size() == 0) begin
            $error("result word with none expected: tlv_type %0d, tlv_length %0d",
                   got.tlv_type, got.tlv_length);
            errors++;
            return;
         end
         exp_w = expected_q.pop_front();
         n_checked++;
         if (exp_w.value_kind != KIND_NONE) n_field++;
         if (exp_w.truncated) n_trunc++;
         if (got.tlv_type !== exp_w.tlv_type) begin
            $error("tlv_type: expected %0d, actual %0d", exp_w.tlv_type, got.tlv_type);
            errors++;
         end
         if (got.tlv_length !== exp_w.tlv_length) begin
            $error("tlv_length: expected %0d, actual %0d", exp_w.tlv_length, got.tlv_length);
            errors++;
         end
         if (got.value_kind !== exp_w.value_kind) begin
            $error("value_kind: expected %0d, actual %0d", exp_w.value_kind, got.value_kind);
            errors++;
         end
         if (got.field_value !== exp_w.field_value) begin
            $error("field_value: expected %h, actual %h", exp_w.field_value, got.field_value);
            errors++;
         end
         if (got.truncated !== exp_w.truncated) begin
            $error("truncated: expected %0b, actual %0b", exp_w.truncated, got.truncated);
            errors++;
         end
         if (got.frame_done !== exp_w.frame_done) begin
            $error("frame_done: expected %0b, actual %0b", exp_w.frame_done, got.frame_done);
            errors++;
         end
      endfunction
   endclass

   // -------------------------------------------------------------------------
   // clock, reset and block
   // -------------------------------------------------------------------------
   logic         clock;
   logic         reset;
   logic         req_valid;
   logic         req_stall;
   ltfe_req_type req_word;
   logic         rsp_valid;
   logic         rsp_stall;
   ltfe_rsp_type rsp_word;

   tlv_scoreboard sb = new();

   logic       calm;          // set during the stretch with no idling on either side
   int         bytes_sent;
   int         frame_count;
   int         cycle_count;
   logic [7:0] frame_q[$];    // payload bytes of the frame being sent

   initial begin
      clock = 1'b0;
   end

   always begin
      #CLK_HALF clock = 1'b1;
      #CLK_HALF clock = 1'b0;
   end

   lldp_tlv_field_extractor_core i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word)
   );

   // receiver back-pressure, changed on the falling edge only
   always @(negedge clock) begin
      rsp_stall <= calm ? 1'b0 : ($urandom_range(0, 99) < IDLE_PCT);
   end

   // both handshakes are sampled here; the byte is noted before the result
   // is checked so any latency works
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) sb.note_byte(req_word);
         if (rsp_valid && !rsp_stall) sb.check_word(rsp_word);
      end
   end

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   // -------------------------------------------------------------------------
   // drivers, entered and left at a falling edge
   // -------------------------------------------------------------------------
   task automatic send_byte(input logic [7:0] b, input logic last);
      ltfe_req_type w;
      // random gaps before the word is offered
      while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      w.data_byte  = b;
      w.frame_last = last;
      req_word  <= w;
      req_valid <= 1'b1;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      bytes_sent++;
      @(negedge clock);
   endtask

   task automatic send_frame();
      foreach (frame_q[i]) send_byte(frame_q[i], i == frame_q.size() - 1);
      frame_count++;
   endtask

   // hold the sender until every expected word is out, then let the block settle
   task automatic drain();
      req_valid <= 1'b0;
      @(negedge clock);
      while (sb.pending() != 0) @(negedge clock);
      repeat (3) @(negedge clock);
   endtask

   // -------------------------------------------------------------------------
   // frame builders
   // -------------------------------------------------------------------------
   function automatic void push_header(logic [6:0] t, logic [8:0] len);
      frame_q.push_back({t, len[8]});
      frame_q.push_back(len[7:0]);
   endfunction

   // value bytes: the first lead_n come from lead, the rest are random
   function automatic void push_value(int len, logic [31:0] lead, int lead_n);
      for (int i = 0; i < len; i++) begin
         if (i < lead_n) frame_q.push_back(lead[31 - 8 * i -: 8]);
         else frame_q.push_back(8'($urandom_range(0, 255)));
      end
   endfunction

   // length around the size that holds the field, mostly exact
   function automatic int pick_len(int nominal);
      int r;
      r = $urandom_range(0, 99);
      if (r < 70) return nominal;
      if (r < 80) return nominal - 1;
      if (r < 90) return nominal + $urandom_range(1, 6);
      return $urandom_range(0, nominal);
   endfunction

   function automatic void push_random_tlv();
      int          r;
      int          len;
      logic [31:0] lead;
      r = $urandom_range(0, 99);
      if (r < 50) begin
         // chassis or port mac, now and then with a wrong subtype
         len  = pick_len(7);
         lead = (r < 25) ? {SUB_CHASSIS_MAC, 24'h0} : {SUB_PORT_MAC, 24'h0};
         if ($urandom_range(0, 9) == 0) lead[31:24] = 8'($urandom_range(0, 255));
         push_header((r < 25) ? TLV_CHASSIS : TLV_PORT, 9'(len));
         push_value(len, lead, 1);
      end else if (r < 70) begin
         // port vlan, now and then with one bit of the oui or subtype flipped
         len  = pick_len(6);
         lead = ORG_PORT_VLAN;
         if ($urandom_range(0, 9) == 0) lead = lead ^ (32'h1 << $urandom_range(0, 31));
         push_header(TLV_ORG, 9'(len));
         push_value(len, lead, 4);
      end else begin
         // any non-end type, short
         len = $urandom_range(0, 12);
         push_header(7'($urandom_range(1, 127)), 9'(len));
         push_value(len, '0, 0);
      end
   endfunction

   function automatic void build_frame(int big_len);
      int ntlv;
      int cut;
      frame_q.delete();
      if ($urandom_range(0, 99) < 12) begin
         // noise: raw bytes with no structure
         repeat ($urandom_range(1, 24)) frame_q.push_back(8'($urandom_range(0, 255)));
         return;
      end
      ntlv = $urandom_range(0, 6);
      repeat (ntlv) push_random_tlv();
      if (big_len > 0) begin
         push_header(7'($urandom_range(1, 127)), 9'(big_len));
         push_value(big_len, '0, 0);
      end
      if ($urandom_range(0, 9) != 0) begin
         // end tlv, its length mostly zero, then bytes that must be ignored
         push_header(TLV_END, ($urandom_range(0, 3) == 0) ? 9'($urandom_range(0, 511)) : 9'd0);
         repeat ($urandom_range(0, 4)) frame_q.push_back(8'($urandom_range(0, 255)));
      end
      if (frame_q.size() == 0) frame_q.push_back(8'($urandom_range(0, 255)));
      // cut short: ends in a header, in a value, on a completing byte or after end
      if ($urandom_range(0, 99) < 20) begin
         cut = $urandom_range(1, frame_q.size());
         while (frame_q.size() > cut) void'(frame_q.pop_back());
      end
   endfunction

   // -------------------------------------------------------------------------
   // stimulus
   // -------------------------------------------------------------------------
   initial begin
      int rand_start;
      int big_len;
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_word    = '0;
      rsp_stall   = 1'b0;
      calm        = 1'b0;
      bytes_sent  = 0;
      frame_count = 0;
      cycle_count = 0;
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // port mac of all ones, vlan of all ones, then end
      frame_q = '{8'h04, 8'h07, 8'h03, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff,
                  8'hfe, 8'h06, 8'h00, 8'h80, 8'hc2, 8'h01, 8'hff, 8'hff,
                  8'h00, 8'h00};
      send_frame();
      // zero length port id, then a max length tlv cut right after its header
      frame_q = '{8'h04, 8'h00, 8'h03, 8'hff};
      send_frame();
      // frame ends inside a header: type 127, length bit 8 set
      frame_q = '{8'hff};
      send_frame();
      // frame ends after end tlv: no word for the trailing byte
      frame_q = '{8'h00, 8'h00, 8'ha5};
      send_frame();
      drain();

      rand_start = bytes_sent;
      while (bytes_sent - rand_start < RANDOM_BYTES) begin
         calm = (bytes_sent - rand_start >= 700) && (bytes_sent - rand_start < 1000);
         // two frames get long tlvs unless built as noise: one at the maximum length, one at or just past 256
         if (frame_count == 12) big_len = 511;
         else if (frame_count == 25) big_len = 256 + $urandom_range(0, 40);
         else big_len = 0;
         build_frame(big_len);
         send_frame();
         if (frame_count == 40) drain();
      end
      calm = 1'b0;
      drain();

      $display("sent %0d payload bytes in %0d frames under random idling and back-pressure",
               bytes_sent, frame_count);
      $display("checked %0d result words: %0d with an extracted field, %0d truncated",
               sb.n_checked, sb.n_field, sb.n_trunc);
      if (sb.errors == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

// ----- lldp_tlv_field_extractor_core.f -----
hdl/ltfe_pkg.sv
hdl/ltfe_parser.sv
hdl/ltfe_out_skid.sv
hdl/lldp_tlv_field_extractor_core.sv
verif/tb_top.sv
